@@ src/ctc_pkg.sv @@
// Shared types and constants for the countdown timer controller.
// No dependencies; imported by the core and its port checker.
`timescale 1ns / 1ps

package ctc_pkg;

	// Timer modes as shown on the result item
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_PAUSE = 2'd2,
		MODE_DONE  = 2'd3
	} mode_t;

	// Input item operations
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_TURN  = 2'd1,
		OP_PRESS = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_STEP  = 2'd0,
		REG_MAX   = 2'd1,
		REG_HOLD  = 2'd2,
		REG_SPARE = 2'd3
	} reg_idx_t;

	localparam int unsigned TICKS_PER_SECOND_DEF = 1000;
	localparam int unsigned MS_MAX      = 4194303;
	localparam int unsigned STEP_W      = 10;
	localparam int unsigned SECS_W      = 12;
	localparam int unsigned HOLD_W      = 18;
	localparam int unsigned CFG_W       = 18;

	localparam logic [STEP_W-1:0] STEP_RST    = 10'd30;
	localparam logic [SECS_W-1:0] MAX_RST     = 12'd3599;
	localparam logic [HOLD_W-1:0] HOLD_RST    = 18'd120000;
	localparam logic [SECS_W-1:0] SECS_RST    = 12'd300;
	localparam logic [HOLD_W-1:0] ELAPSED_MAX = 18'd262143;

	// Result item width (m_axis_tdata)
	localparam int unsigned OUT_W = 32;

endpackage

@@ src/countdown_timer_controller_core.sv @@
// Countdown timer controller core; depends on ctc_pkg.
// An item taken into the input register moves on to the result register when that register is
// empty or its item is being taken. One item per cycle is sustained while the result side
// takes items; whole seconds and a sub-second tick count replace a divider.
// Reset (arst_n low): idle, 300 s remaining and set, step 30 s, clamp 3599 s,
// hold 120000 ticks, both item registers empty.
`timescale 1ns / 1ps

module countdown_timer_controller_core
	import ctc_pkg::*;
#(
	parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	// input items
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,  // [3:0] turn_amount, [7:4] zero
	input  logic [1:0]        s_axis_tuser,  // [1:0] operation
	// result items
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [1:0] mode, [13:2] seconds_left, [25:14] set_seconds,
	// [26] keep_awake, [27] alarm_fired, [31:28] zero
	output logic [OUT_W-1:0]  m_axis_tdata
);

	// sub-second counter runs 1..TICKS_PER_SECOND
	localparam int unsigned FW = $clog2(TICKS_PER_SECOND + 1);
	localparam logic [FW-1:0] FRAC_FULL = FW'(TICKS_PER_SECOND);
	localparam logic [FW-1:0] FRAC_ONE  = FW'(1);
	// start saturates the millisecond count above this many seconds
	localparam int unsigned SAT_LIMIT = MS_MAX / TICKS_PER_SECOND;
	localparam int unsigned SAT_SECS  = (MS_MAX + TICKS_PER_SECOND - 1) / TICKS_PER_SECOND;
	localparam int unsigned SAT_FRAC  = MS_MAX - (SAT_SECS - 1) * TICKS_PER_SECOND;

	// configuration registers
	logic [STEP_W-1:0] step_q;
	logic [SECS_W-1:0] max_q;
	logic [HOLD_W-1:0] hold_q;

	// timer state
	mode_t             mode_q, mode_d;
	logic [SECS_W-1:0] rem_secs_q, rem_secs_d;
	logic [SECS_W-1:0] chosen_q, chosen_d;
	logic [SECS_W-1:0] run_secs_q, run_secs_d;
	logic [FW-1:0]     frac_q, frac_d;
	logic [HOLD_W-1:0] elapsed_q, elapsed_d;
	logic              alarm_d;
	logic              awake_d;

	// input stage
	logic              valid_s1;
	op_t               op_s1;
	logic signed [3:0] turn_s1;

	// result register
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic              advance;
	logic signed [14:0] turn_prod;
	logic signed [15:0] turn_sum;
	logic              start_sat;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
			max_q  <= MAX_RST;
			hold_q <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STEP:  step_q <= cfg_wdata[STEP_W-1:0];
				REG_MAX:   max_q  <= cfg_wdata[SECS_W-1:0];
				REG_HOLD:  hold_q <= cfg_wdata[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= op_t'(s_axis_tuser);
			turn_s1 <= $signed(s_axis_tdata[3:0]);
		end
	end

	// knob arithmetic: remaining + turn * step, clamped later
	assign turn_prod = 15'(turn_s1) * $signed({5'b0, step_q});
	assign turn_sum  = $signed({4'b0, rem_secs_q}) + 16'(turn_prod);
	assign start_sat = 32'(rem_secs_q) > SAT_LIMIT;

	// next state for the item in the input register
	always_comb begin
		mode_d     = mode_q;
		rem_secs_d = rem_secs_q;
		chosen_d   = chosen_q;
		run_secs_d = run_secs_q;
		frac_d     = frac_q;
		elapsed_d  = elapsed_q;
		alarm_d    = 1'b0;
		case (op_s1)
			OP_TICK: begin
				if (mode_q == MODE_RUN) begin
					if (run_secs_q == '0 || (run_secs_q == 12'd1 && frac_q <= FRAC_ONE)) begin
						// countdown reaches zero
						mode_d     = MODE_DONE;
						rem_secs_d = '0;
						run_secs_d = '0;
						elapsed_d  = '0;
						alarm_d    = 1'b1;
					end else if (frac_q <= FRAC_ONE) begin
						run_secs_d = run_secs_q - 12'd1;
						frac_d     = FRAC_FULL;
						rem_secs_d = run_secs_q - 12'd1;
					end else begin
						frac_d     = frac_q - FRAC_ONE;
						rem_secs_d = run_secs_q;
					end
				end else if (mode_q == MODE_DONE) begin
					if (elapsed_q != ELAPSED_MAX)
						elapsed_d = elapsed_q + 18'd1;
				end
			end
			OP_TURN: begin
				if (mode_q == MODE_IDLE || mode_q == MODE_PAUSE) begin
					if (turn_sum < 0)
						rem_secs_d = '0;
					else if (turn_sum > $signed({4'b0, max_q}))
						rem_secs_d = max_q;
					else
						rem_secs_d = turn_sum[SECS_W-1:0];
					chosen_d = rem_secs_d;
				end
			end
			OP_PRESS: begin
				if (mode_q == MODE_IDLE || mode_q == MODE_PAUSE) begin
					if (rem_secs_q != '0) begin
						mode_d = MODE_RUN;
						if (start_sat) begin
							run_secs_d = SECS_W'(SAT_SECS);
							frac_d     = FW'(SAT_FRAC);
						end else begin
							run_secs_d = rem_secs_q;
							frac_d     = FRAC_FULL;
						end
					end
				end else if (mode_q == MODE_RUN) begin
					rem_secs_d = run_secs_q;
					mode_d     = MODE_PAUSE;
				end else begin
					rem_secs_d = chosen_q;
					mode_d     = MODE_IDLE;
					elapsed_d  = '0;
				end
			end
			default: ;
		endcase
		awake_d = (mode_d == MODE_DONE) && (elapsed_d < hold_q);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			rem_secs_q <= SECS_RST;
			chosen_q   <= SECS_RST;
			run_secs_q <= '0;
			frac_q     <= '0;
			elapsed_q  <= '0;
		end else if (advance) begin
			mode_q     <= mode_d;
			rem_secs_q <= rem_secs_d;
			chosen_q   <= chosen_d;
			run_secs_q <= run_secs_d;
			frac_q     <= frac_d;
			elapsed_q  <= elapsed_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= {4'b0, alarm_d, awake_d, chosen_d, rem_secs_d, mode_d};
	end

endmodule

@@ src/ctc_checker.sv @@
// Port-level checks for the countdown timer controller core, and its bind.
// Depends on ctc_pkg and countdown_timer_controller_core.
`timescale 1ns / 1ps

module ctc_checker
	import ctc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	// a stalled result item holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	// the alarm comes only with the done mode and zero seconds left
	a_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[27] |->
			m_axis_tdata[1:0] == MODE_DONE && m_axis_tdata[13:2] == '0)
		else $error("alarm outside done or with time left");

	// keep-awake only while done
	a_awake: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[1:0] == MODE_DONE)
		else $error("keep-awake outside done");

	// padding bits stay clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:28] == '0)
		else $error("padding bits set");

endmodule

bind countdown_timer_controller_core ctc_checker u_ctc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
